// ===== rtl/tlpc_pkg.sv =====
package tlpc_pkg;

  localparam int SAMPLES_DEF = 5;
  localparam int ECHO_FIELDS = 5;

  localparam int ECHO_W     = 15;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STREAK_W   = 8;
  localparam int LEVEL_W    = 7;
  localparam int TIME_W     = 32;

  // Echo to distance: floor(us * 1715 / 1000) as a multiply by a reciprocal.
  localparam int SOUND_W = 11;
  localparam logic [SOUND_W-1:0] SOUND_K = 11'd1715;
  localparam int PROD_W  = ECHO_W + SOUND_W;
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP_K = 27'd68719477;
  localparam int RECIP_SH = 36;

  localparam logic [DIST_W-1:0] MAX_DIST     = 16'd40000;
  localparam logic [DIST_W-1:0] MIN_VALID    = 16'd200;
  localparam logic [DIST_W:0]   WINDOW_SLACK = 17'd500;
  localparam logic [LEVEL_W-1:0] PCT_SCALE   = 7'd100;
  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

  localparam int DIVD_W    = 24;
  localparam int DVS_W     = 16;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITER  = DIVD_W / DIV_STEPS;

  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd4;

  localparam logic [DIST_W-1:0]   RST_BOTTOM  = 16'd1513;
  localparam logic [DIST_W-1:0]   RST_FULL    = 16'd1150;
  localparam logic [DIST_W-1:0]   RST_START   = 16'd150;
  localparam logic [STREAK_W-1:0] RST_STABLE  = 8'd3;
  localparam logic [15:0]         RST_CONFIRM = 16'd1000;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_FULL     = 2'd2,
    ST_LOW      = 2'd3
  } status_t;

  typedef struct packed {
    logic cap;
    logic e_mul;
    logic e_div;
    logic e_acc;
    logic div_start;
    logic div_pct;
    logic avg_load;
    logic hgt;
    logic pct_load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_echo;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/tlpc_div.sv =====
module tlpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tlpc_pkg::DIVD_W-1:0] dividend,
  input  logic [tlpc_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [tlpc_pkg::DIVD_W-1:0] quotient
);
  import tlpc_pkg::*;

  localparam int CNT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  rem_nxt;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVD_W-1:0] quo_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial   = {rem_nxt, quo_nxt[DIVD_W-1]};
      quo_nxt = {quo_nxt[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/tlpc_datapath.sv =====
module tlpc_datapath #(
  parameter int SAMPLES = tlpc_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_a,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_b,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_c,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_d,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_e,
  input  logic                            in_overflow_raw,
  input  logic [tlpc_pkg::TIME_W-1:0]     in_now_ms,
  input  tlpc_pkg::cmd_t                  cmd,
  output tlpc_pkg::sts_t                  sts,
  output logic [tlpc_pkg::DIST_W-1:0]     out_avg_distance,
  output logic [tlpc_pkg::DIST_W-1:0]     out_water_height,
  output logic [tlpc_pkg::LEVEL_W-1:0]    out_level_percent,
  output logic [1:0]                      out_status_code,
  output logic                            out_overflow_confirmed,
  output logic                            out_pump_on,
  output logic                            out_buzzer_alert
);
  import tlpc_pkg::*;

  localparam int NUSE  = (SAMPLES < ECHO_FIELDS) ? SAMPLES : ECHO_FIELDS;
  localparam int IDX_W = (NUSE > 1) ? $clog2(NUSE) : 1;
  localparam int CNT_W = $clog2(NUSE + 1);
  localparam int SUM_W = DIST_W + CNT_W;

  logic [DIST_W-1:0]   bottom_r;
  logic [DIST_W-1:0]   full_r;
  logic [DIST_W-1:0]   start_h_r;
  logic [STREAK_W-1:0] stable_r;
  logic [15:0]         confirm_r;

  logic [ECHO_W-1:0]   echo_in [ECHO_FIELDS];
  logic [ECHO_W-1:0]   echo_r [NUSE];
  logic                raw_r;
  logic [TIME_W-1:0]   now_r;

  logic [IDX_W-1:0]    idx_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DIST_W-1:0]   q_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIST_W-1:0]   avg_r;
  logic [DIST_W-1:0]   height_r;
  logic [LEVEL_W-1:0]  level_r;

  logic                pump_r;
  logic [STREAK_W-1:0] high_r;
  logic [STREAK_W-1:0] low_r;
  logic                timing_r;
  logic [TIME_W-1:0]   ovf_start_r;
  logic                latched_r;

  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [DIST_W-1:0]   echo_dist;
  logic                dist_ok;
  logic [DIST_W-1:0]   height_nxt;
  logic [TIME_W-1:0]   ovf_start_nxt;
  logic [TIME_W-1:0]   elapsed;
  logic [DIVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quo;

  logic                pump_nxt;
  logic [STREAK_W-1:0] high_nxt;
  logic [STREAK_W-1:0] low_nxt;
  status_t             status_nxt;

  assign echo_in[0] = in_echo_a;
  assign echo_in[1] = in_echo_b;
  assign echo_in[2] = in_echo_c;
  assign echo_in[3] = in_echo_d;
  assign echo_in[4] = in_echo_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bottom_r  <= RST_BOTTOM;
      full_r    <= RST_FULL;
      start_h_r <= RST_START;
      stable_r  <= RST_STABLE;
      confirm_r <= RST_CONFIRM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOTTOM:  bottom_r  <= cfg_data;
        CFG_FULL:    full_r    <= cfg_data;
        CFG_START:   start_h_r <= cfg_data;
        CFG_STABLE:  stable_r  <= cfg_data[STREAK_W-1:0];
        CFG_CONFIRM: confirm_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign recip_prod = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(RECIP_K);

  always_comb begin
    echo_dist = q_r;
    if (q_r == '0 || q_r > MAX_DIST) begin
      echo_dist = bottom_r;
    end
    dist_ok = (echo_dist > MIN_VALID) && ({1'b0, echo_dist} < ({1'b0, bottom_r} + WINDOW_SLACK));
  end

  always_comb begin
    height_nxt = (bottom_r > avg_r) ? (bottom_r - avg_r) : '0;
    if (height_nxt > full_r) begin
      height_nxt = full_r;
    end
  end

  assign ovf_start_nxt = timing_r ? ovf_start_r : now_r;
  assign elapsed       = now_r - ovf_start_nxt;

  assign div_dvd = cmd.div_pct ? (DIVD_W'(height_r) * DIVD_W'(PCT_SCALE)) : DIVD_W'(sum_r);
  assign div_dvs = cmd.div_pct ? full_r : DVS_W'(cnt_r);

  tlpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sts.div_done  = div_done;
  assign sts.last_echo = (idx_r == IDX_W'(NUSE - 1));

  always_comb begin
    pump_nxt   = pump_r;
    high_nxt   = '0;
    low_nxt    = '0;
    status_nxt = ST_NORMAL;
    if (latched_r) begin
      pump_nxt   = 1'b0;
      status_nxt = ST_OVERFLOW;
    end else begin
      if (height_r >= full_r) begin
        high_nxt = (high_r == STREAK_MAX) ? STREAK_MAX : high_r + 1'b1;
      end
      if (height_r <= start_h_r) begin
        low_nxt = (low_r == STREAK_MAX) ? STREAK_MAX : low_r + 1'b1;
      end
      if (pump_r && high_nxt >= stable_r) begin
        status_nxt = ST_FULL;
        pump_nxt   = 1'b0;
        high_nxt   = '0;
      end else if (!pump_r && low_nxt >= stable_r) begin
        status_nxt = ST_LOW;
        pump_nxt   = 1'b1;
        low_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_r      <= 1'b1;
      high_r      <= '0;
      low_r       <= '0;
      timing_r    <= 1'b0;
      ovf_start_r <= '0;
      latched_r   <= 1'b0;
    end else begin
      if (cmd.hgt) begin
        if (raw_r) begin
          timing_r    <= 1'b1;
          ovf_start_r <= ovf_start_nxt;
          if (elapsed >= TIME_W'(confirm_r)) begin
            latched_r <= 1'b1;
          end
        end else begin
          timing_r    <= 1'b0;
          ovf_start_r <= '0;
          latched_r   <= 1'b0;
        end
      end
      if (cmd.commit) begin
        pump_r <= pump_nxt;
        high_r <= high_nxt;
        low_r  <= low_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      for (int i = 0; i < NUSE; i++) begin
        echo_r[i] <= echo_in[i];
      end
      raw_r <= in_overflow_raw;
      now_r <= in_now_ms;
      idx_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.e_mul) begin
      prod_r <= PROD_W'(echo_r[idx_r]) * PROD_W'(SOUND_K);
    end
    if (cmd.e_div) begin
      q_r <= recip_prod[RECIP_SH +: DIST_W];
    end
    if (cmd.e_acc) begin
      idx_r <= idx_r + 1'b1;
      if (dist_ok) begin
        sum_r <= sum_r + SUM_W'(echo_dist);
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.avg_load) begin
      avg_r <= (cnt_r == '0) ? bottom_r : div_quo[DIST_W-1:0];
    end
    if (cmd.hgt) begin
      height_r <= height_nxt;
    end
    if (cmd.pct_load) begin
      level_r <= (full_r == '0) ? '0 : div_quo[LEVEL_W-1:0];
    end
    if (cmd.commit) begin
      out_avg_distance       <= avg_r;
      out_water_height       <= height_r;
      out_level_percent      <= level_r;
      out_status_code        <= status_nxt;
      out_overflow_confirmed <= latched_r;
      out_pump_on            <= pump_nxt;
      out_buzzer_alert       <= latched_r;
    end
  end

endmodule

// ===== rtl/tlpc_ctrl.sv =====
module tlpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tlpc_pkg::sts_t sts,
  output tlpc_pkg::cmd_t cmd
);
  import tlpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_MUL,
    S_E_DIV,
    S_E_ACC,
    S_AVG_GO,
    S_AVG_WAIT,
    S_HGT,
    S_PCT_GO,
    S_PCT_WAIT,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_E_MUL;
        end
      end
      S_E_MUL: begin
        cmd.e_mul = 1'b1;
        state_nxt = S_E_DIV;
      end
      S_E_DIV: begin
        cmd.e_div = 1'b1;
        state_nxt = S_E_ACC;
      end
      S_E_ACC: begin
        cmd.e_acc = 1'b1;
        state_nxt = sts.last_echo ? S_AVG_GO : S_E_MUL;
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = S_HGT;
        end
      end
      S_HGT: begin
        cmd.hgt   = 1'b1;
        state_nxt = S_PCT_GO;
      end
      S_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_pct   = 1'b1;
        state_nxt     = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (sts.div_done) begin
          cmd.pct_load = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/tank_level_pump_controller.sv =====
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    in_echo_a..e, in_overflow_raw, in_now_ms
// out       out        out_valid / out_ready  out_avg_distance .. out_buzzer_alert
//
// Each item runs the multiply, reciprocal-shift and accumulate states for each of the
// min(SAMPLES, 5) echoes, then makes two passes of the shared two-bit-per-cycle divider.
// Reset is synchronous and active low; it loads the register defaults and pump on.
// A new transfer is taken while the previous result waits; the next result is held
// until the output register is free.
module tank_level_pump_controller #(
  parameter int SAMPLES = tlpc_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_a,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_b,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_c,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_d,
  input  logic [tlpc_pkg::ECHO_W-1:0]     in_echo_e,
  input  logic                            in_overflow_raw,
  input  logic [tlpc_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tlpc_pkg::DIST_W-1:0]     out_avg_distance,
  output logic [tlpc_pkg::DIST_W-1:0]     out_water_height,
  output logic [tlpc_pkg::LEVEL_W-1:0]    out_level_percent,
  output logic [1:0]                      out_status_code,
  output logic                            out_overflow_confirmed,
  output logic                            out_pump_on,
  output logic                            out_buzzer_alert
);
  import tlpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlpc_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_echo_a              (in_echo_a),
    .in_echo_b              (in_echo_b),
    .in_echo_c              (in_echo_c),
    .in_echo_d              (in_echo_d),
    .in_echo_e              (in_echo_e),
    .in_overflow_raw        (in_overflow_raw),
    .in_now_ms              (in_now_ms),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_avg_distance       (out_avg_distance),
    .out_water_height       (out_water_height),
    .out_level_percent      (out_level_percent),
    .out_status_code        (out_status_code),
    .out_overflow_confirmed (out_overflow_confirmed),
    .out_pump_on            (out_pump_on),
    .out_buzzer_alert       (out_buzzer_alert)
  );

endmodule
